// ----- rtl/bba_pkg.sv -----
// Shared types and codes for the bitmap block allocator.
`default_nettype none
package bba_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned WORD_LG = 5;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_REQUEST = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_SPACE = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_RESERVED = 3'd3;
   localparam logic [2:0] ST_USED     = 3'd4;

   typedef struct packed {
      logic clr_wr;
      logic capture;
      logic rd;
      logic commit;
   } bba_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_alloc;
      logic scan_done;
      logic out_busy;
   } bba_stat_type;

endpackage
`default_nettype wire

// ----- rtl/bba_if.sv -----
// Request and response channel interfaces.
`default_nettype none
interface bba_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [9:0] block_index;
   modport source (output valid, output opcode, output block_index, input ready);
   modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface bba_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] granted_block;
   logic [2:0] status;
   logic [9:0] used_count;
   logic [9:0] free_count;
   modport source (output valid, output granted_block, output status,
                   output used_count, output free_count, input ready);
   modport sink   (input valid, input granted_block, input status,
                   input used_count, input free_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/bba_ctrl.sv -----
// Sequencer for clearing pass, map reads, scan and commit.
`default_nettype none
module bba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_fire,
   input  wire bba_pkg::bba_stat_type stat,
   output bba_pkg::bba_cmd_type       cmd,
   output logic                       req_ready
);
   import bba_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = stat.is_alloc ? S_SCAN : S_CHECK;
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_CHECK;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         S_CHECK: begin
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/bba_datapath.sv -----
// Used-map memory, block counter, bit search and response register.
`default_nettype none
module bba_datapath #(
   parameter int unsigned NUM_BLOCKS     = 512,
   parameter int unsigned RESERVED_START = 127,
   parameter int unsigned RESERVED_COUNT = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bba_pkg::bba_cmd_type  cmd,
   output bba_pkg::bba_stat_type      stat,
   input  wire logic [1:0]            in_opcode,
   input  wire logic [9:0]            in_block_index,
   input  wire logic                  out_ready,
   output logic                       out_valid,
   output logic [8:0]                 out_granted_block,
   output logic [2:0]                 out_status,
   output logic [9:0]                 out_used_count,
   output logic [9:0]                 out_free_count
);
   import bba_pkg::*;

   localparam int unsigned NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int unsigned CW        = $clog2(NUM_BLOCKS + 1);
   localparam int unsigned RESV_END  = RESERVED_START + RESERVED_COUNT;
   localparam int unsigned RESV_HI   = (RESV_END < NUM_BLOCKS) ? RESV_END : NUM_BLOCKS;
   localparam int unsigned RESV_IN   = (RESV_HI > RESERVED_START) ?
                                       (RESV_HI - RESERVED_START) : 0;

   localparam logic [1:0] CNT_HOLD = 2'b00;
   localparam logic [1:0] CNT_INC  = 2'b01;
   localparam logic [1:0] CNT_DEC  = 2'b10;

   function automatic logic [WORD_W-1:0] resv_bits(input logic [31:0] base);
      logic [WORD_W-1:0] m;
      logic [31:0]       b;
      for (int j = 0; j < WORD_W; j++) begin
         b    = base + 32'(j);
         m[j] = (b >= RESERVED_START) && (b < RESV_END) && (b < NUM_BLOCKS);
      end
      return m;
   endfunction

   function automatic logic [WORD_W-1:0] over_bits(input logic [31:0] base);
      logic [WORD_W-1:0] m;
      for (int j = 0; j < WORD_W; j++) begin
         m[j] = (base + 32'(j)) >= NUM_BLOCKS;
      end
      return m;
   endfunction

   logic [WORD_W-1:0] mem [NUM_WORDS];

   logic [1:0]        op_ff;
   logic [9:0]        idx_ff;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     rd_word_ff;
   logic [WORD_W-1:0] rd_ff;
   logic [CW-1:0]     used_ff;
   logic [CW-1:0]     used_in;
   logic              out_valid_ff;
   logic [8:0]        gb_ff;
   logic [2:0]        st_ff;
   logic [9:0]        uc_ff;
   logic [9:0]        fc_ff;

   logic [31:0]       idx32;
   logic [31:0]       named_word32;
   logic              idx_in_range;
   logic              idx_reserved;
   logic [AW-1:0]     rd_addr;
   logic [31:0]       rd_base;
   logic [WORD_W-1:0] free_bits;
   logic [WORD_W-1:0] first_free;
   logic [WORD_LG-1:0] pos;
   logic              hit;
   logic              named_bit;
   logic [WORD_W-1:0] named_mask;
   logic [2:0]        res_status;
   logic [31:0]       res_block;
   logic              do_write;
   logic [WORD_W-1:0] wr_data;
   logic [1:0]        cnt_step;
   logic [31:0]       used_ext;
   logic [31:0]       free_ext;

   assign idx32        = 32'(idx_ff);
   assign named_word32 = idx32 >> WORD_LG;
   assign idx_in_range = idx32 < NUM_BLOCKS;
   assign idx_reserved = (idx32 >= RESERVED_START) && (idx32 < RESV_END);
   assign rd_addr      = (op_ff == OP_ALLOC) ? addr_ff :
                         (idx_in_range ? named_word32[AW-1:0] : '0);
   assign rd_base      = 32'(rd_word_ff) << WORD_LG;

   assign free_bits  = ~rd_ff & ~over_bits(rd_base);
   assign first_free = free_bits & (~free_bits + 1'b1);
   assign hit        = |free_bits;

   always_comb begin
      pos = '0;
      for (int k = 0; k < WORD_LG; k++) begin
         for (int j = 0; j < WORD_W; j++) begin
            if (((j >> k) & 1) == 1) pos[k] = pos[k] | first_free[j];
         end
      end
   end

   assign named_mask = WORD_W'(1) << idx_ff[WORD_LG-1:0];
   assign named_bit  = |(rd_ff & named_mask);

   always_comb begin
      res_status = ST_OK;
      res_block  = idx32;
      do_write   = 1'b0;
      wr_data    = rd_ff;
      cnt_step   = CNT_HOLD;
      if (op_ff == OP_ALLOC) begin
         res_block = rd_base + 32'(pos);
         if (hit) begin
            do_write = 1'b1;
            wr_data  = rd_ff | first_free;
            cnt_step = CNT_INC;
         end else begin
            res_status = ST_NO_SPACE;
         end
      end else if (op_ff == OP_UNUSED || !idx_in_range) begin
         res_status = ST_RANGE;
      end else if (idx_reserved) begin
         res_status = ST_RESERVED;
      end else if (op_ff == OP_REQUEST) begin
         if (named_bit) begin
            res_status = ST_USED;
         end else begin
            do_write = 1'b1;
            wr_data  = rd_ff | named_mask;
            cnt_step = CNT_INC;
         end
      end else if (named_bit) begin
         do_write = 1'b1;
         wr_data  = rd_ff & ~named_mask;
         cnt_step = CNT_DEC;
      end
   end

   always_comb begin
      case (cnt_step)
         CNT_INC: used_in = used_ff + 1'b1;
         CNT_DEC: used_in = used_ff - 1'b1;
         default: used_in = used_ff;
      endcase
   end

   assign used_ext = 32'(used_in);
   assign free_ext = NUM_BLOCKS - used_ext;

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[addr_ff] <= resv_bits(32'(addr_ff) << WORD_LG);
      end else if (cmd.commit && do_write) begin
         mem[rd_word_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_ff      <= mem[rd_addr];
         rd_word_ff <= rd_addr;
      end
      if (cmd.capture) begin
         op_ff  <= in_opcode;
         idx_ff <= in_block_index;
      end
      if (cmd.commit) begin
         gb_ff <= (res_status == ST_OK) ? res_block[8:0] : '0;
         st_ff <= res_status;
         uc_ff <= used_ext[9:0];
         fc_ff <= free_ext[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         used_ff      <= CW'(RESV_IN);
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            addr_ff <= '0;
         end else if (cmd.clr_wr || cmd.rd) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (cmd.commit) begin
            used_ff      <= used_in;
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.clr_last  = (addr_ff == AW'(NUM_WORDS - 1));
   assign stat.is_alloc  = (op_ff == OP_ALLOC);
   assign stat.scan_done = hit || (rd_word_ff == AW'(NUM_WORDS - 1));
   assign stat.out_busy  = out_valid_ff && !out_ready;

   assign out_valid         = out_valid_ff;
   assign out_granted_block = gb_ff;
   assign out_status        = st_ff;
   assign out_used_count    = uc_ff;
   assign out_free_count    = fc_ff;

endmodule
`default_nettype wire

// ----- rtl/bitmap_block_allocator_top.sv -----
// Top level of the bitmap first-fit block allocator.
//
//   channel  dir  transaction
//   req_ch   in   opcode, block_index
//   rsp_ch   out  granted_block, status, used_count, free_count
//
// After reset a clearing pass writes the used map, one 32-bit word a cycle, over
// every word of the map, with req_ch.ready low.
// Request and release pass through accept, map read and commit.
// Allocate reads the map from word 0, one word per cycle through its read port, until
// it finds a free block or reaches the last word, then commits the lowest free block.
// A response waiting on rsp_ch does not block acceptance; a finished result
// stalls only while the previous one is still held.
`default_nettype none
module bitmap_block_allocator_top #(
   parameter int unsigned NUM_BLOCKS     = 512,
   parameter int unsigned RESERVED_START = 127,
   parameter int unsigned RESERVED_COUNT = 1
) (
   input wire logic  clock,
   input wire logic  reset,
   bba_req_if.sink   req_ch,
   bba_rsp_if.source rsp_ch
);
   import bba_pkg::*;

   bba_cmd_type  cmd;
   bba_stat_type stat;
   logic         ready;

   assign req_ch.ready = ready;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_ch.valid && ready),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (ready)
   );

   bba_datapath #(
      .NUM_BLOCKS     (NUM_BLOCKS),
      .RESERVED_START (RESERVED_START),
      .RESERVED_COUNT (RESERVED_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .in_opcode         (req_ch.opcode),
      .in_block_index    (req_ch.block_index),
      .out_ready         (rsp_ch.ready),
      .out_valid         (rsp_ch.valid),
      .out_granted_block (rsp_ch.granted_block),
      .out_status        (rsp_ch.status),
      .out_used_count    (rsp_ch.used_count),
      .out_free_count    (rsp_ch.free_count)
   );

endmodule
`default_nettype wire

// ----- sim/bitmap_block_allocator_top_tb.sv -----
// Self-checking testbench for the bitmap block allocator: random and directed transactions.
`timescale 1ns / 100ps
module bitmap_block_allocator_top_tb;
   import bba_pkg::*;

   localparam int unsigned NUM_BLOCKS     = 512;
   localparam int unsigned RESERVED_START = 127;
   localparam int unsigned RESERVED_COUNT = 1;
   localparam int unsigned STALL_LIMIT    = 400;
   localparam int unsigned DRAIN_CYCLES   = 40;
   localparam int unsigned MAX_PRINTS     = 40;

   typedef struct {
      logic [1:0]  op;
      logic [9:0]  idx;
      int unsigned gap;
   } alloc_cmd_type;

   typedef struct {
      logic [8:0] granted;
      logic [2:0] status;
      logic [9:0] used;
      logic [9:0] free;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bba_req_if req_ch ();
   bba_rsp_if rsp_ch ();

   bitmap_block_allocator_top #(
      .NUM_BLOCKS     (NUM_BLOCKS),
      .RESERVED_START (RESERVED_START),
      .RESERVED_COUNT (RESERVED_COUNT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   alloc_cmd_type  cmd_backlog[$];
   alloc_rsp_type  results_due[$];
   alloc_rsp_type  rsp_want;
   logic [NUM_BLOCKS-1:0] block_used;
   int unsigned blocks_in_use;
   int unsigned peak_in_use;
   int unsigned error_count;
   int unsigned cmds_accepted;
   int unsigned rsps_seen;
   int unsigned status_seen[5];
   int unsigned drv_wait;
   int unsigned drv_calm;
   int unsigned rsp_hold;
   int unsigned rsp_calm;
   int unsigned idle_cycles;

   task automatic flag_error(input string msg);
      if (error_count < MAX_PRINTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic bit in_reserved(input logic [9:0] blk);
      return blk >= RESERVED_START && blk < RESERVED_START + RESERVED_COUNT;
   endfunction

   // Updates the shadow map and returns the response the transaction should produce.
   function automatic alloc_rsp_type model_allocator_op(input logic [1:0] op,
                                                        input logic [9:0] idx);
      alloc_rsp_type r;
      logic [9:0] b;
      bit found;
      r.granted = '0;
      r.status  = ST_OK;
      found     = 1'b0;
      if (op == OP_ALLOC) begin
         r.status = ST_NO_SPACE;
         for (b = 0; b < NUM_BLOCKS && !found; b++) begin
            if (!in_reserved(b) && !block_used[b]) begin
               block_used[b] = 1'b1;
               blocks_in_use++;
               r.granted = b[8:0];
               r.status  = ST_OK;
               found     = 1'b1;
            end
         end
      end else if (op == OP_UNUSED || idx >= NUM_BLOCKS) begin
         r.status = ST_RANGE;
      end else if (in_reserved(idx)) begin
         r.status = ST_RESERVED;
      end else if (op == OP_REQUEST) begin
         if (block_used[idx]) begin
            r.status = ST_USED;
         end else begin
            block_used[idx] = 1'b1;
            blocks_in_use++;
            r.granted = idx[8:0];
         end
      end else begin
         if (block_used[idx]) begin
            block_used[idx] = 1'b0;
            blocks_in_use--;
         end
         r.granted = idx[8:0];
      end
      r.used = blocks_in_use[9:0];
      r.free = 10'(NUM_BLOCKS - blocks_in_use);
      return r;
   endfunction

   task automatic push_cmd(input logic [1:0] op, input logic [9:0] idx);
      alloc_cmd_type c;
      c.op  = op;
      c.idx = idx;
      if (drv_calm > 0) begin
         c.gap = 0;
         drv_calm--;
      end else begin
         c.gap = $urandom_range(0, 3);
         if ($urandom_range(0, 15) == 0)
            drv_calm = $urandom_range(16, 48);
      end
      cmd_backlog.push_back(c);
   endtask

   function automatic logic [9:0] pick_index();
      int unsigned sel;
      sel = $urandom_range(0, 31);
      if (sel == 0)
         return 10'(RESERVED_START);
      else if (sel < 3)
         return 10'($urandom_range(NUM_BLOCKS, 1023));
      else
         return 10'($urandom_range(0, NUM_BLOCKS - 1));
   endfunction

   // Weights are percentages for allocate, request and release; the rest is the unused opcode.
   task automatic push_random(input int unsigned count, input int unsigned w_alloc,
                              input int unsigned w_req, input int unsigned w_rel);
      int unsigned n;
      int unsigned roll;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < w_alloc)
            push_cmd(OP_ALLOC, 10'($urandom_range(0, 1023)));
         else if (roll < w_alloc + w_req)
            push_cmd(OP_REQUEST, pick_index());
         else if (roll < w_alloc + w_req + w_rel)
            push_cmd(OP_RELEASE, pick_index());
         else
            push_cmd(OP_UNUSED, 10'($urandom_range(0, 1023)));
      end
   endtask

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         drv_wait     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            results_due.push_back(model_allocator_op(req_ch.opcode, req_ch.block_index));
            cmds_accepted++;
            if (blocks_in_use > peak_in_use)
               peak_in_use = blocks_in_use;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (cmd_backlog.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (drv_wait < cmd_backlog[0].gap) begin
               req_ch.valid <= 1'b0;
               drv_wait     <= drv_wait + 1;
            end else begin
               req_ch.valid       <= 1'b1;
               req_ch.opcode      <= cmd_backlog[0].op;
               req_ch.block_index <= cmd_backlog[0].idx;
               drv_wait           <= 0;
               void'(cmd_backlog.pop_front());
            end
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsps_seen++;
            if (rsp_ch.status <= ST_USED)
               status_seen[rsp_ch.status]++;
            if (results_due.size() == 0) begin
               flag_error($sformatf("unexpected response: block %0d status %0d",
                                    rsp_ch.granted_block, rsp_ch.status));
            end else begin
               rsp_want = results_due.pop_front();
               if (rsp_ch.granted_block !== rsp_want.granted)
                  flag_error($sformatf("rsp %0d granted_block %0d, want %0d", rsps_seen,
                                       rsp_ch.granted_block, rsp_want.granted));
               if (rsp_ch.status !== rsp_want.status)
                  flag_error($sformatf("rsp %0d status %0d, want %0d", rsps_seen,
                                       rsp_ch.status, rsp_want.status));
               if (rsp_ch.used_count !== rsp_want.used)
                  flag_error($sformatf("rsp %0d used_count %0d, want %0d", rsps_seen,
                                       rsp_ch.used_count, rsp_want.used));
               if (rsp_ch.free_count !== rsp_want.free)
                  flag_error($sformatf("rsp %0d free_count %0d, want %0d", rsps_seen,
                                       rsp_ch.free_count, rsp_want.free));
            end
            if (rsp_calm > 0) begin
               rsp_hold = 0;
               rsp_calm--;
            end else begin
               rsp_hold = $urandom_range(0, 3);
               if ($urandom_range(0, 15) == 0)
                  rsp_calm = $urandom_range(16, 48);
            end
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ch.ready <= (rsp_hold == 0);
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned k;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_ALLOC;
      req_ch.block_index = '0;
      rsp_ch.ready       = 1'b0;
      error_count   = 0;
      cmds_accepted = 0;
      rsps_seen     = 0;
      drv_calm      = 0;
      rsp_calm      = 0;
      idle_cycles   = 0;
      blocks_in_use = 0;
      for (k = 0; k < 5; k++)
         status_seen[k] = 0;
      block_used = '0;
      for (k = 0; k < NUM_BLOCKS; k++) begin
         if (in_reserved(10'(k))) begin
            block_used[k] = 1'b1;
            blocks_in_use++;
         end
      end
      peak_in_use = blocks_in_use;

      // directed: first-fit order, range edges, reserved block, double request/release
      push_cmd(OP_ALLOC,   10'd0);
      push_cmd(OP_ALLOC,   10'd1023);
      push_cmd(OP_REQUEST, 10'd0);
      push_cmd(OP_REQUEST, 10'd511);
      push_cmd(OP_REQUEST, 10'd511);
      push_cmd(OP_REQUEST, 10'(RESERVED_START));
      push_cmd(OP_RELEASE, 10'(RESERVED_START));
      push_cmd(OP_REQUEST, 10'(RESERVED_START - 1));
      push_cmd(OP_REQUEST, 10'(RESERVED_START + RESERVED_COUNT));
      push_cmd(OP_REQUEST, 10'd512);
      push_cmd(OP_RELEASE, 10'd1023);
      push_cmd(OP_REQUEST, 10'd682);
      push_cmd(OP_RELEASE, 10'd341);
      push_cmd(OP_UNUSED,  10'd5);
      push_cmd(OP_UNUSED,  10'd1023);
      push_cmd(OP_RELEASE, 10'd300);
      push_cmd(OP_RELEASE, 10'd0);
      push_cmd(OP_ALLOC,   10'd0);
      push_cmd(OP_RELEASE, 10'd1);
      push_cmd(OP_RELEASE, 10'd1);
      push_cmd(OP_ALLOC,   10'd0);
      push_cmd(OP_RELEASE, 10'd511);
      push_cmd(OP_ALLOC,   10'd0);

      // fill until full and beyond, drain, then a mixed load
      push_random(600, 92, 3, 3);
      push_random(400, 15, 12, 70);
      push_random(300, 40, 28, 28);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || req_ch.valid || results_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transactions in, %0d out; peak blocks in use %0d of %0d",
               cmds_accepted, rsps_seen, peak_in_use, NUM_BLOCKS);
      $display("status ok %0d, no space %0d, range %0d, reserved %0d, in use %0d; errors %0d",
               status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_RANGE],
               status_seen[ST_RESERVED], status_seen[ST_USED], error_count);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
